FILE: hw/rtl/bttf_pkg.sv
// Bass/treble tone filter: shared types, constants and arithmetic helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bttf_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PCT_W       = 7;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TREBLE = 2'd1;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Q1.15 coefficients of the lowpass; they sum to exactly one.
   localparam logic signed [16:0] KEEP_Q = 17'sd29491;
   localparam logic signed [16:0] TAKE_Q = 17'sd3277;
   localparam logic signed [16:0] ONE_Q  = 17'sd32768;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      STEP_KEEP,
      STEP_TAKE,
      STEP_ORIG,
      STEP_TREB,
      STEP_BASS,
      STEP_SUM
   } step_type;

   typedef struct packed {
      logic     go;
      step_type step;
   } dp_cmd_type;

   // floor(pct * 32768 / 100), pct clamped to 100.
   // = pct*327 + floor(pct*17/25), the last via pct*22287 >> 15.
   function automatic logic [GAIN_W-1:0] gain_of(input logic [PCT_W-1:0] pct);
      logic [PCT_W-1:0]  p;
      logic [GAIN_W-1:0] whole;
      logic [21:0]       frac;
      p     = (pct > PCT_FULL) ? PCT_FULL : pct;
      whole = GAIN_W'(p) * 16'd327;
      frac  = 22'(p) * 22'd22287;
      return whole + GAIN_W'(frac >> 15);
   endfunction

   // Divide by 32768, rounding toward zero.
   function automatic logic signed [18:0] trunc_q15(input logic signed [33:0] p);
      logic signed [33:0] r;
      r = p[33] ? (p + 34'sd32767) : p;
      return r[33:15];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bttf_datapath.sv
// Tone filter datapath: gain registers, filter state and one shared multiplier.
// Steps are driven by bttf_ctrl; uses bttf_pkg.
`default_nettype none

module bttf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bttf_pkg::dp_cmd_type               cmd,
   input  bttf_pkg::req_type                  req_data,
   input  logic                               csr_write,
   input  logic [bttf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bttf_pkg::PCT_W-1:0]         csr_data,
   output bttf_pkg::rsp_type                  rsp_data
);
   import bttf_pkg::*;

   logic [GAIN_W-1:0]          bass_gain_ff;
   logic [GAIN_W-1:0]          treb_gain_ff;
   logic signed [SAMPLE_W-1:0] avg_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       last_ff;
   logic signed [33:0]         prod_ff;
   logic signed [31:0]         acc_ff;
   logic signed [SAMPLE_W-1:0] avgn_ff;
   logic signed [19:0]         sum_ff;
   rsp_type                    rsp_ff;

   logic signed [16:0] orig_gain;
   logic signed [16:0] diff;
   logic signed [16:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [33:0] mul_p;
   logic signed [31:0] acc_sum;
   logic signed [18:0] avg_full;
   logic signed [18:0] part;
   logic signed [19:0] part_x2;
   logic signed [19:0] sum_in;

   assign orig_gain = ONE_Q - $signed({1'b0, bass_gain_ff}) - $signed({1'b0, treb_gain_ff});
   assign diff      = {x_ff[SAMPLE_W-1], x_ff} - {prev_ff[SAMPLE_W-1], prev_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         STEP_KEEP: begin
            mul_a = {avg_ff[SAMPLE_W-1], avg_ff};
            mul_b = KEEP_Q;
         end
         STEP_TAKE: begin
            mul_a = {x_ff[SAMPLE_W-1], x_ff};
            mul_b = TAKE_Q;
         end
         STEP_ORIG: begin
            mul_a = {x_ff[SAMPLE_W-1], x_ff};
            mul_b = orig_gain;
         end
         STEP_TREB: begin
            mul_a = diff;
            mul_b = $signed({1'b0, treb_gain_ff});
         end
         STEP_BASS: begin
            mul_a = {avgn_ff[SAMPLE_W-1], avgn_ff};
            mul_b = $signed({1'b0, bass_gain_ff});
         end
         STEP_SUM: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = 34'(mul_a) * 34'(mul_b);
   assign acc_sum  = acc_ff + prod_ff[31:0];
   assign avg_full = trunc_q15(34'(acc_sum));
   assign part     = trunc_q15(prod_ff);
   assign part_x2  = {part, 1'b0};
   assign sum_in   = sum_ff + part_x2;

   // Configuration and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bass_gain_ff <= '0;
         treb_gain_ff <= '0;
         avg_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         if (csr_write && (csr_index == CSR_BASS)) begin
            bass_gain_ff <= gain_of(csr_data);
         end
         if (csr_write && (csr_index == CSR_TREBLE)) begin
            treb_gain_ff <= gain_of(csr_data);
         end
         if (cmd.go && (cmd.step == STEP_SUM)) begin
            avg_ff  <= last_ff ? '0 : avgn_ff;
            prev_ff <= last_ff ? '0 : x_ff;
         end
      end
   end

   // Working registers, no reset.
   always_ff @(posedge clock) begin
      if (cmd.go) begin
         unique case (cmd.step)
            STEP_KEEP: begin
               x_ff    <= req_data.sample_in;
               last_ff <= req_data.last_in;
               prod_ff <= mul_p;
            end
            STEP_TAKE: begin
               acc_ff  <= prod_ff[31:0];
               prod_ff <= mul_p;
            end
            STEP_ORIG: begin
               avgn_ff <= avg_full[SAMPLE_W-1:0];
               prod_ff <= mul_p;
            end
            STEP_TREB: begin
               sum_ff  <= {part[18], part};
               prod_ff <= mul_p;
            end
            STEP_BASS: begin
               sum_ff  <= sum_in;
               prod_ff <= mul_p;
            end
            STEP_SUM: begin
               rsp_ff.sample_out <= sat16(sum_in);
               rsp_ff.last_out   <= last_ff;
            end
            default: begin
               prod_ff <= prod_ff;
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bttf_ctrl.sv
// Tone filter controller: sequences the multiply steps and owns the handshakes.
// Drives bttf_datapath by command; uses bttf_pkg.
`default_nettype none

module bttf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bttf_pkg::dp_cmd_type cmd
);
   import bttf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE,
      S_ORIG,
      S_TREB,
      S_BASS,
      S_SUM
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd.go       = 1'b0;
      cmd.step     = STEP_KEEP;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmd.step = STEP_KEEP;
            cmd.go   = req_valid;
            if (req_valid) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            cmd.step = STEP_TAKE;
            cmd.go   = 1'b1;
            state_in = S_ORIG;
         end
         S_ORIG: begin
            cmd.step = STEP_ORIG;
            cmd.go   = 1'b1;
            state_in = S_TREB;
         end
         S_TREB: begin
            cmd.step = STEP_TREB;
            cmd.go   = 1'b1;
            state_in = S_BASS;
         end
         S_BASS: begin
            cmd.step = STEP_BASS;
            cmd.go   = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            // wait here while the output register is still full
            cmd.step = STEP_SUM;
            cmd.go   = !rsp_valid_ff || rsp_ready;
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bass_treble_tone_filter.sv
// Bass/treble tone filter, top level: controller, datapath and checks.
// Instantiates bttf_ctrl and bttf_datapath; uses bttf_pkg.
//
// Usage:
//  - req_*: one signed 16-bit sample per item, with last_in marking the end of
//    a recording; after that item the running average and previous sample
//    return to zero.
//  - rsp_*: one tone-adjusted sample per item, in order, last_out copied.
//  - csr_*: index 0 bass percent, index 1 treble percent (7 bits, values
//    above 100 act as 100); other indexes are ignored. Always ready; write
//    only while no item is in flight.
// Sequence: an item is taken in the idle state, then passes the take, orig,
// treble, bass and sum states, and rsp_valid is set at the sum step. The five
// products share one multiplier, one product a cycle; new items enter only in idle.
// Stall: the result waits in an output register; the next item is accepted
// and worked on meanwhile, holding only at its final step until rsp_ready.
// Reset: synchronous; gains, average and previous sample clear to zero.
`default_nettype none

module bass_treble_tone_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bttf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bttf_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bttf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bttf_pkg::PCT_W-1:0]       csr_data
);
   import bttf_pkg::*;

   dp_cmd_type cmd;

   assign csr_ready = 1'b1;

   bttf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bttf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   // a freshly raised result must follow an accepted item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 6))
      else $error("result raised without an item six cycles before");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_data.last_out == $past(req_data.last_in, 6)))
      else $error("end-of-recording flag lost");

endmodule

`default_nettype wire
